// ----- rtl/prq_pkg.sv -----
// Package with the entry type, request and status codes of the priority run queue.
`timescale 1ns / 1ps

package prq_pkg;

  localparam int unsigned QueueDepthDefault = 64;
  localparam int unsigned TaskW = 16;
  localparam int unsigned PrioW = 2;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_PICK   = 2'd2,
    REQ_STEAL  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_DONE   = 3'd0,
    ST_FULL   = 3'd1,
    ST_DUP    = 3'd2,
    ST_ABSENT = 3'd3,
    ST_EMPTY  = 3'd4
  } status_e;

  localparam logic [PrioW-1:0] PrioHigh = 2'd0;
  localparam logic [PrioW-1:0] PrioLow  = 2'd2;
  localparam logic [PrioW-1:0] PrioNone = 2'd3;

  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [TaskW-1:0] task_id;
  } entry_t;

  typedef struct packed {
    logic [TaskW-1:0] picked;
    status_e          status;
  } result_t;

endpackage

// ----- rtl/prq_mem.sv -----
// Single-port-write, single-port-read queue memory with registered read data.
`timescale 1ns / 1ps

module prq_mem
  import prq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  parameter int unsigned AW = $clog2(QUEUE_DEPTH)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  entry_t        wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output entry_t        rd_data_o
);

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/prq_ctrl.sv -----
// Request sequencer: scans the queue memory, appends, and closes gaps by shifting.
`timescale 1ns / 1ps

module prq_ctrl
  import prq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  parameter int unsigned AW = $clog2(QUEUE_DEPTH),
  parameter int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  req_e             req_i,
  input  logic [TaskW-1:0] task_id_i,
  input  logic [PrioW-1:0] task_priority_i,
  input  logic [TaskW-1:0] running_task_i,
  output logic             idle_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output result_t          res_o,
  output logic [CW-1:0]    count_o,
  output logic             wr_en_o,
  output logic [AW-1:0]    wr_addr_o,
  output entry_t           wr_data_o,
  output logic             rd_en_o,
  output logic [AW-1:0]    rd_addr_o,
  input  entry_t           rd_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_e;

  localparam logic [CW-1:0] DepthCount = CW'(QUEUE_DEPTH);

  state_e           state_q;
  req_e             req_q;
  logic [TaskW-1:0] id_q;
  logic [PrioW-1:0] prio_q;
  logic [TaskW-1:0] run_q;
  logic [CW-1:0]    count_q;
  logic [CW-1:0]    ra_q;
  logic             rv_q;
  logic [AW-1:0]    ri_q;
  logic             found_q;
  logic [AW-1:0]    pos_q;
  logic [PrioW-1:0] best_q;
  logic [TaskW-1:0] picked_q;
  status_e          status_q;

  logic scan_end;
  logic shift_end;
  logic skip_hit;

  assign rd_en_o   = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (ra_q < count_q);
  assign rd_addr_o = ra_q[AW-1:0];
  assign scan_end  = (state_q == S_SCAN) && !rd_en_o && !rv_q;
  assign shift_end = (state_q == S_SHIFT) && !rd_en_o && !rv_q;
  assign skip_hit  = (req_q == REQ_STEAL) && (rd_data_i.task_id == run_q);

  always_comb begin
    wr_en_o   = 1'b0;
    wr_addr_o = count_q[AW-1:0];
    wr_data_o = '{prio: prio_q, task_id: id_q};
    if (scan_end && (req_q == REQ_ADD) && !found_q) begin
      wr_en_o = 1'b1;
    end else if ((state_q == S_SHIFT) && rv_q) begin
      wr_en_o   = 1'b1;
      wr_addr_o = ri_q - AW'(1);
      wr_data_o = rd_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      rv_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            req_q    <= req_i;
            id_q     <= task_id_i;
            prio_q   <= (task_priority_i == PrioNone) ? PrioLow : task_priority_i;
            run_q    <= running_task_i;
            ra_q     <= '0;
            rv_q     <= 1'b0;
            found_q  <= 1'b0;
            best_q   <= PrioNone;
            picked_q <= '0;
            pos_q    <= '0;
            status_q <= ST_DONE;
            if ((req_i == REQ_ADD) && (count_q == DepthCount)) begin
              status_q <= ST_FULL;
              state_q  <= S_FINISH;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rv_q <= rd_en_o;
          ri_q <= ra_q[AW-1:0];
          if (rd_en_o) begin
            ra_q <= ra_q + CW'(1);
          end
          if (rv_q) begin
            case (req_q)
              REQ_ADD, REQ_REMOVE: begin
                if (!found_q && (rd_data_i.task_id == id_q)) begin
                  found_q <= 1'b1;
                  pos_q   <= ri_q;
                end
              end
              default: begin
                if (!skip_hit && (rd_data_i.prio < best_q)) begin
                  found_q  <= 1'b1;
                  best_q   <= rd_data_i.prio;
                  pos_q    <= ri_q;
                  picked_q <= rd_data_i.task_id;
                end
              end
            endcase
          end
          if (scan_end) begin
            case (req_q)
              REQ_ADD: begin
                if (found_q) begin
                  status_q <= ST_DUP;
                end else begin
                  count_q <= count_q + CW'(1);
                end
                state_q <= S_FINISH;
              end
              REQ_REMOVE: begin
                if (found_q) begin
                  ra_q    <= CW'(pos_q) + CW'(1);
                  state_q <= S_SHIFT;
                end else begin
                  status_q <= ST_ABSENT;
                  state_q  <= S_FINISH;
                end
              end
              default: begin
                if (found_q) begin
                  ra_q    <= CW'(pos_q) + CW'(1);
                  state_q <= S_SHIFT;
                end else begin
                  status_q <= ST_EMPTY;
                  picked_q <= '0;
                  state_q  <= S_FINISH;
                end
              end
            endcase
          end
        end
        S_SHIFT: begin
          rv_q <= rd_en_o;
          ri_q <= ra_q[AW-1:0];
          if (rd_en_o) begin
            ra_q <= ra_q + CW'(1);
          end
          if (shift_end) begin
            count_q <= count_q - CW'(1);
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_FINISH);
  assign res_o       = '{picked: picked_q, status: status_q};
  assign count_o     = count_q;

endmodule

// ----- rtl/priority_run_queue.sv -----
// Top level of the priority run queue: sequencer, queue memory and output register.
`timescale 1ns / 1ps
//
// Channels: an input channel (in_valid_i/in_ready_o) carries one request per
// transaction: add, remove, best pick or steal pick, with task id, priority
// and the running task. The output channel (out_valid_o/out_ready_i) returns
// exactly one result transaction per request: picked task, status and the
// entry count after the request.
// Operation: a request sweeps the queue memory once, one entry per cycle, and
// a remove or pick then shifts the entries behind the removed one down, one
// per cycle, through the same read and write ports. An add to a full queue
// skips the sweep and returns its full status directly.
// One request is in work at a time; in_ready_o is high while the sequencer
// is idle, also while a finished result waits in the output register.
// Reset: the entry count clears; the queue memory is not cleared, as entries
// at or above the count are never read. No clearing pass is needed.
// Stall: a held result keeps the output register; the next result waits in
// the sequencer until the register frees, and input is then held off.

module priority_run_queue
  import prq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  parameter int unsigned AW = $clog2(QUEUE_DEPTH),
  parameter int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       req_type_i,
  input  logic [TaskW-1:0] task_id_i,
  input  logic [PrioW-1:0] task_priority_i,
  input  logic [TaskW-1:0] running_task_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [TaskW-1:0] picked_task_o,
  output logic [2:0]       status_o,
  output logic [CW-1:0]    entry_count_o
);

  logic             idle;
  logic             start;
  logic             res_valid;
  logic             slot_free;
  result_t          res;
  logic [CW-1:0]    count;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  entry_t           wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  entry_t           rd_data;

  logic             out_valid_q;
  logic [TaskW-1:0] picked_q;
  status_e          status_q;
  logic [CW-1:0]    count_q;

  assign in_ready_o = idle;
  assign start      = in_valid_i && idle;
  assign slot_free  = !out_valid_q || out_ready_i;

  prq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .req_i          (req_e'(req_type_i)),
    .task_id_i      (task_id_i),
    .task_priority_i(task_priority_i),
    .running_task_i (running_task_i),
    .idle_o         (idle),
    .res_valid_o    (res_valid),
    .res_ready_i    (slot_free),
    .res_o          (res),
    .count_o        (count),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data)
  );

  prq_mem #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .AW         (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && slot_free) begin
      picked_q <= res.picked;
      status_q <= res.status;
      count_q  <= count;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign picked_task_o = picked_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (entry_count_o <= CW'(QUEUE_DEPTH)))
    else $error("entry count above queue depth");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL)) |-> (entry_count_o == CW'(QUEUE_DEPTH)))
    else $error("full status with free entries");

  a_fail_no_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_DONE)) |-> (picked_task_o == '0))
    else $error("failed request returned a task");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request taken while one is in work");

endmodule

// ----- dv/tb_top.sv -----
// Testbench for the priority run queue: directed cases, fill and drain, random mix.
`timescale 1ns / 1ps

module tb_top;
  import prq_pkg::*;

  localparam int unsigned Depth = QueueDepthDefault;
  localparam logic [PrioW-1:0] PrioNormal = 2'd1;

  typedef struct {
    logic [TaskW-1:0] picked;
    status_e          status;
    logic [6:0]       count;
  } reply_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  req_e             req_kind;
  logic [TaskW-1:0] req_id;
  logic [PrioW-1:0] req_prio;
  logic [TaskW-1:0] req_running;
  logic             out_valid;
  logic             out_ready;
  logic [TaskW-1:0] picked_task;
  logic [2:0]       status;
  logic [6:0]       entry_count;

  logic [TaskW-1:0] shadow_ids [Depth];
  logic [PrioW-1:0] shadow_prio [Depth];
  int unsigned      shadow_count;
  reply_t           awaited_replies [$];
  reply_t           got;
  reply_t           head;
  int unsigned      fail_count;
  bit               no_idle;

  priority_run_queue i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .req_type_i      (req_kind),
    .task_id_i       (req_id),
    .task_priority_i (req_prio),
    .running_task_i  (req_running),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .picked_task_o   (picked_task),
    .status_o        (status),
    .entry_count_o   (entry_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int shadow_find(logic [TaskW-1:0] id);
    for (int i = 0; i < int'(shadow_count); i++) begin
      if (shadow_ids[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void shadow_delete(int pos);
    for (int i = pos; i + 1 < int'(shadow_count); i++) begin
      shadow_ids[i]  = shadow_ids[i + 1];
      shadow_prio[i] = shadow_prio[i + 1];
    end
    shadow_count--;
  endfunction

  function automatic reply_t apply_request(req_e kind, logic [TaskW-1:0] id,
                                           logic [PrioW-1:0] prio,
                                           logic [TaskW-1:0] running);
    reply_t           r;
    int               pos;
    logic [PrioW-1:0] best;
    r.picked = '0;
    r.status = ST_DONE;
    pos      = -1;
    best     = PrioNone;
    case (kind)
      REQ_ADD: begin
        if (shadow_count >= Depth) begin
          r.status = ST_FULL;
        end else if (shadow_find(id) >= 0) begin
          r.status = ST_DUP;
        end else begin
          shadow_ids[shadow_count]  = id;
          shadow_prio[shadow_count] = (prio > PrioLow) ? PrioLow : prio;
          shadow_count++;
        end
      end
      REQ_REMOVE: begin
        pos = shadow_find(id);
        if (pos < 0) r.status = ST_ABSENT;
        else shadow_delete(pos);
      end
      default: begin
        for (int i = 0; i < int'(shadow_count); i++) begin
          if (kind == REQ_STEAL && shadow_ids[i] == running) continue;
          if (shadow_prio[i] < best) begin
            best = shadow_prio[i];
            pos  = i;
            if (best == PrioHigh) break;
          end
        end
        if (pos < 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.picked = shadow_ids[pos];
          shadow_delete(pos);
        end
      end
    endcase
    r.count = 7'(shadow_count);
    return r;
  endfunction

  function automatic int unsigned idle_cycles();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TaskW-1:0] queued_or_random_id();
    if (shadow_count == 0) return 16'($urandom);
    return shadow_ids[$urandom_range(0, shadow_count - 1)];
  endfunction

  task automatic issue_request(req_e kind, logic [TaskW-1:0] id, logic [PrioW-1:0] prio,
                               logic [TaskW-1:0] running);
    int unsigned gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_kind    <= kind;
    req_id      <= id;
    req_prio    <= prio;
    req_running <= running;
    do @(posedge clk); while (!in_ready);
    awaited_replies.push_back(apply_request(kind, id, prio, running));
  endtask

  task automatic flag_failure(string what, reply_t want, reply_t seen);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s: expected picked %0d status %0d count %0d, got picked %0d status %0d count %0d",
               $realtime, what, want.picked, want.status, want.count,
               seen.picked, seen.status, seen.count);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got.picked = picked_task;
      got.status = status_e'(status);
      got.count  = entry_count;
      if (awaited_replies.size() == 0) begin
        head = '{picked: '0, status: ST_DONE, count: '0};
        flag_failure("unexpected transaction", head, got);
      end else begin
        head = awaited_replies.pop_front();
        if (got.picked !== head.picked || got.status !== head.status ||
            got.count !== head.count) begin
          flag_failure("mismatch", head, got);
        end
      end
    end
  end

  initial begin : ready_driver
    int unsigned hold;
    out_ready = 1'b0;
    hold = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        hold = idle_cycles();
      end
    end
  end

  task automatic test_directed_cases();
    issue_request(REQ_ADD, 16'hFFFF, PrioHigh, 16'hFFFF);
    issue_request(REQ_ADD, 16'h0000, PrioNone, 16'h0000);
    issue_request(REQ_ADD, 16'h0001, PrioNormal, 16'h0000);
    issue_request(REQ_ADD, 16'h0001, PrioLow, 16'h0000);
    issue_request(REQ_REMOVE, 16'h1234, PrioHigh, 16'h0000);
    issue_request(REQ_PICK, 16'h0001, PrioHigh, 16'hFFFF);
    issue_request(REQ_STEAL, 16'h0000, PrioHigh, 16'h0001);
    issue_request(REQ_PICK, 16'h0000, PrioHigh, 16'h0000);
    issue_request(REQ_PICK, 16'h0000, PrioHigh, 16'h0000);
    issue_request(REQ_STEAL, 16'h0000, PrioHigh, 16'h0000);
    issue_request(REQ_ADD, 16'h0007, PrioLow, 16'h0000);
    issue_request(REQ_STEAL, 16'h0000, PrioHigh, 16'h0007);
    issue_request(REQ_ADD, 16'h0000, PrioLow, 16'h0000);
    issue_request(REQ_STEAL, 16'h0007, PrioHigh, 16'h0000);
    issue_request(REQ_ADD, 16'h0005, PrioLow, 16'h0000);
    issue_request(REQ_ADD, 16'h0006, PrioLow, 16'h0000);
    issue_request(REQ_PICK, 16'h0000, PrioHigh, 16'h0000);
    issue_request(REQ_REMOVE, 16'h0006, PrioHigh, 16'h0000);
    issue_request(REQ_REMOVE, 16'h0006, PrioHigh, 16'h0000);
    issue_request(REQ_ADD, 16'h0009, PrioHigh, 16'h0000);
    issue_request(REQ_STEAL, 16'h0000, PrioHigh, 16'h0009);
    issue_request(REQ_REMOVE, 16'h0009, PrioHigh, 16'hFFFF);
  endtask

  task automatic test_fill_and_drain();
    logic [TaskW-1:0] victim;
    int unsigned      roll;
    while (shadow_count < Depth) begin
      issue_request(REQ_ADD, 16'($urandom), 2'($urandom_range(0, 3)), 16'($urandom));
    end
    issue_request(REQ_ADD, queued_or_random_id(), PrioHigh, 16'($urandom));
    issue_request(REQ_ADD, 16'($urandom), PrioLow, 16'($urandom));
    while (shadow_count > 0) begin
      roll   = $urandom_range(0, 2);
      victim = queued_or_random_id();
      if (roll == 0) begin
        issue_request(REQ_REMOVE, victim, 2'($urandom_range(0, 3)), 16'($urandom));
      end else if (roll == 1) begin
        issue_request(REQ_PICK, 16'($urandom), 2'($urandom_range(0, 3)), victim);
      end else begin
        issue_request(REQ_STEAL, 16'($urandom), 2'($urandom_range(0, 3)), victim);
      end
    end
  endtask

  task automatic test_random_mix(int unsigned items);
    int unsigned      roll;
    req_e             kind;
    logic [TaskW-1:0] id;
    logic [TaskW-1:0] running;
    logic [PrioW-1:0] prio;
    for (int unsigned n = 0; n < items; n++) begin
      if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      roll    = $urandom_range(0, 99);
      kind    = (roll < 40) ? REQ_ADD : (roll < 60) ? REQ_REMOVE :
                (roll < 80) ? REQ_PICK : REQ_STEAL;
      roll    = $urandom_range(0, 9);
      id      = (roll < 4) ? queued_or_random_id() :
                (roll < 8) ? 16'($urandom_range(0, 95)) : 16'($urandom);
      prio    = 2'($urandom_range(0, 3));
      roll    = $urandom_range(0, 9);
      running = (roll < 5) ? queued_or_random_id() : (roll < 6) ? '0 : 16'($urandom);
      issue_request(kind, id, prio, running);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    req_kind     = REQ_ADD;
    req_id       = '0;
    req_prio     = '0;
    req_running  = '0;
    shadow_count = 0;
    fail_count   = 0;
    no_idle      = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_fill_and_drain();
    test_fill_and_drain();
    test_random_mix(1080);
    in_valid <= 1'b0;
    for (int n = 0; n < 100000 && awaited_replies.size() != 0; n++) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && awaited_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
